FILE: src/itda_pkg.sv
// Shared constants and types for the integer to decimal ASCII core.
`default_nettype none
package itda_pkg;

  // Width of the converted word; the input field is cast to this width.
  localparam int WORD_WIDTH = 32;
  localparam int VALUE_W    = 32;

  // Decimal digits needed for WORD_WIDTH bits: floor(W * log10(2)) + 1.
  localparam int NUM_DIGITS = (WORD_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int BIT_CNT_W  = $clog2(WORD_WIDTH + 1);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam int CHAR_W = 8;
  localparam int TXT_W  = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [3:0]        DAB_THRESH  = 4'd5;
  localparam logic [3:0]        DAB_ADD     = 4'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } dbl_stat_t;

endpackage
`default_nettype wire

FILE: src/itda_dabble.sv
// Bit-serial shift-and-add-3 binary to BCD converter, one input bit per cycle.
`default_nettype none
module itda_dabble
  import itda_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [WORD_WIDTH-1:0] mag,
  output dbl_stat_t                  stat,
  output logic [BCD_W-1:0]           bcd
);

  logic [WORD_WIDTH-1:0] bin_r;
  logic [BCD_W-1:0]      bcd_r;
  logic [BCD_W-1:0]      adj;
  logic [BIT_CNT_W-1:0]  cnt_r;
  logic                  busy_r;
  logic                  done_r;

  // digits at 5 or above get 3 added before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= DAB_THRESH) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + DAB_ADD;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= BIT_CNT_W'(WORD_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == BIT_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= mag;
      bcd_r <= '0;
    end else if (busy_r) begin
      {bcd_r, bin_r} <= {adj[BCD_W-2:0], bin_r, 1'b0};
    end
  end

  assign stat.busy = busy_r | done_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule
`default_nettype wire

FILE: src/itda_emit.sv
// Leading zero skip and character serializer with the output register.
`default_nettype none
module itda_emit
  import itda_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [BCD_W-1:0] bcd,
  input  wire logic             neg,
  output logic                  busy,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [CHAR_W-1:0]     out_char,
  output logic [TXT_W-1:0]      out_pos,
  output logic [TXT_W-1:0]      out_len,
  output logic                  out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]           state_r;
  logic [BCD_W-1:0]     bcd_r;
  logic [DIG_CNT_W-1:0] nd_r;
  logic                 neg_r;
  logic [TXT_W-1:0]     pos_r;
  logic [TXT_W-1:0]     len_r;
  logic                 ov_r;
  logic [CHAR_W-1:0]    oc_r;
  logic [TXT_W-1:0]     op_r;
  logic [TXT_W-1:0]     ol_r;
  logic                 olast_r;
  logic                 load;
  logic [3:0]           top_dig;

  assign top_dig = bcd_r[BCD_W-1 -: 4];
  assign load    = (state_r == ST_EMIT) && (!ov_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (top_dig != 4'd0 || nd_r == DIG_CNT_W'(1)) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load && !neg_r && nd_r == DIG_CNT_W'(1)) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      bcd_r <= bcd;
      nd_r  <= DIG_CNT_W'(NUM_DIGITS);
      neg_r <= neg;
    end else if (state_r == ST_SKIP) begin
      if (top_dig == 4'd0 && nd_r != DIG_CNT_W'(1)) begin
        bcd_r <= {bcd_r[BCD_W-5:0], 4'd0};
        nd_r  <= nd_r - 1'b1;
      end else begin
        len_r <= TXT_W'(nd_r) + TXT_W'(neg_r);
        pos_r <= '0;
      end
    end else if (load) begin
      pos_r <= pos_r + 1'b1;
      op_r  <= pos_r;
      ol_r  <= len_r;
      if (neg_r) begin
        oc_r    <= ASCII_MINUS;
        olast_r <= 1'b0;
        neg_r   <= 1'b0;
      end else begin
        oc_r    <= ASCII_ZERO + {4'd0, top_dig};
        olast_r <= (nd_r == DIG_CNT_W'(1));
        bcd_r   <= {bcd_r[BCD_W-5:0], 4'd0};
        nd_r    <= nd_r - 1'b1;
      end
    end
  end

  assign busy      = (state_r != ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_pos   = op_r;
  assign out_len   = ol_r;
  assign out_last  = olast_r;

endmodule
`default_nettype wire

FILE: src/integer_to_decimal_ascii_core.sv
// Top level: binary word to decimal ASCII text, one character per output item.
//
// Input channel (in_*): in_tdata carries the 32-bit word, in_tuser selects
// unsigned (0) or signed two's complement (1). One item is taken at a time;
// in_tready is high only while the core holds no work.
// Output channel (out_*): one item per character, most significant digit
// first, a leading '-' for negative signed words. out_tdata also carries the
// character's position and the total text length; out_tlast marks the final
// character.
// Timing: after an item is taken the bit-serial BCD converter shifts through
// the word bit by bit, a handover step follows, then leading zeros are dropped
// at one digit per cycle (up to 9), a final step fixes the text length, then
// characters leave one per cycle while out_tready is high. The next item is
// taken once the last character has left.
// Reset (rst_n low, synchronous) clears all control state; no output is
// pending afterwards. When out_tready is low the current character holds in
// the output register and the serializer waits.
`default_nettype none
module integer_to_decimal_ascii_core
  import itda_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [VALUE_W-1:0] in_tdata,   // [31:0] value
  input  wire logic               in_tuser,   // [0] func
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [15:0]             out_tdata,  // [7:0] character, [11:8] position,
                                              // [15:12] text_length
  output logic                    out_tlast   // last
);

  logic                  in_acc;
  logic [WORD_WIDTH-1:0] word;
  logic                  neg;
  logic [WORD_WIDTH-1:0] mag;
  logic                  neg_r;
  dbl_stat_t             dstat;
  logic [BCD_W-1:0]      bcd;
  logic                  ebusy;
  logic [CHAR_W-1:0]     o_char;
  logic [TXT_W-1:0]      o_pos;
  logic [TXT_W-1:0]      o_len;

  assign in_tready = !dstat.busy && !ebusy;
  assign in_acc    = in_tvalid && in_tready;
  assign word      = WORD_WIDTH'(in_tdata);
  assign neg       = in_tuser && word[WORD_WIDTH-1];
  // most negative word wraps back to itself and reads as unsigned
  assign mag       = neg ? (~word + 1'b1) : word;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg_r <= neg;
    end
  end

  itda_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .mag   (mag),
    .stat  (dstat),
    .bcd   (bcd)
  );

  itda_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dstat.done),
    .bcd       (bcd),
    .neg       (neg_r),
    .busy      (ebusy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (o_char),
    .out_pos   (o_pos),
    .out_len   (o_len),
    .out_last  (out_tlast)
  );

  assign out_tdata = {o_len, o_pos, o_char};

  a_conv_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> dstat.busy)
    else $error("converter did not start after an item was taken");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while characters are pending");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (TXT_W'(o_pos + 1'b1) == o_len)))
    else $error("last mark disagrees with position and length");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    dstat.done |-> !out_tvalid)
    else $error("conversion finished while emitter still busy");

endmodule
`default_nettype wire

FILE: sim/itda_text_checker.sv
// Checker for the decimal ASCII core: predicts the text of every accepted word and compares.
module itda_text_checker
  import itda_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tready,
  input  wire logic [VALUE_W-1:0] in_tdata,   // [31:0] value
  input  wire logic               in_tuser,   // [0] func
  input  wire logic               out_tvalid,
  input  wire logic               out_tready,
  input  wire logic [15:0]        out_tdata,  // [7:0] character, [11:8] position,
                                              // [15:12] text_length
  input  wire logic               out_tlast,  // last
  output int                      mismatches,
  output int                      chars_due
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [TXT_W-1:0]  pos;
    logic [TXT_W-1:0]  len;
    logic              last;
  } text_char_t;

  text_char_t due_q[$];
  int         err_cnt = 0;

  initial begin
    mismatches = 0;
    chars_due  = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < 100)
      $display("mismatch: %s got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  // Queue the characters of one word's text, sign first, then digits MSD first.
  function automatic void push_decimal_text(input logic signed_mode,
                                            input logic [VALUE_W-1:0] raw);
    logic [63:0]       mask;
    logic [63:0]       mag;
    logic              neg;
    logic [CHAR_W-1:0] digits[24];
    int                nd;
    int                len;
    int                k;
    text_char_t        c;
    mask = (WORD_WIDTH >= 64) ? '1 : ((64'd1 << WORD_WIDTH) - 64'd1);
    mag  = 64'(raw) & mask;
    neg  = signed_mode && mag[WORD_WIDTH-1];
    // most negative word wraps back onto itself and reads as unsigned
    if (neg) mag = (~mag + 64'd1) & mask;
    nd = 0;
    if (mag == 0) begin
      digits[0] = ASCII_ZERO;
      nd = 1;
    end
    while (mag != 0 && nd < 23) begin
      digits[nd] = ASCII_ZERO + CHAR_W'(mag % 10);
      mag = mag / 10;
      nd++;
    end
    len = nd + (neg ? 1 : 0);
    for (k = 0; k < len; k++) begin
      if (neg && k == 0) c.ch = ASCII_MINUS;
      else               c.ch = digits[len - 1 - k];
      c.pos  = TXT_W'(k);
      c.len  = TXT_W'(len);
      c.last = (k + 1 == len);
      due_q.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          report_mismatch("character with none expected", out_tdata[7:0], 0);
        end else begin
          want = due_q.pop_front();
          if (out_tdata[7:0] !== want.ch)
            report_mismatch("character", out_tdata[7:0], want.ch);
          if (out_tdata[11:8] !== want.pos)
            report_mismatch("position", out_tdata[11:8], want.pos);
          if (out_tdata[15:12] !== want.len)
            report_mismatch("text_length", out_tdata[15:12], want.len);
          if (out_tlast !== want.last)
            report_mismatch("last", out_tlast, want.last);
        end
      end
      if (in_tvalid && in_tready)
        push_decimal_text(in_tuser, in_tdata);
    end
    mismatches <= err_cnt;
    chars_due  <= due_q.size();
  end

  final begin
    if (due_q.size() != 0 && err_cnt == 0)
      $display("mismatch: %0d characters never arrived", due_q.size());
  end

endmodule

FILE: sim/tb.sv
// Testbench top for the decimal ASCII core: stimulus, output back-pressure and verdict.
module tb;
  import itda_pkg::*;

  localparam int RAND_ITEMS = 400;
  localparam int CALM_ITEMS = 40;
  localparam int LIMIT      = 500000;
  localparam int DRAIN      = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata = '0;
  logic               in_tuser = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [15:0]        out_tdata;
  logic               out_tlast;

  int   mismatches;
  int   chars_due;
  int   cycles = 0;
  int   stall_left = 0;
  logic calm = 1'b0;

  integer_to_decimal_ascii_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  itda_text_checker text_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .chars_due  (chars_due)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver back-pressure: random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input logic signed_mode, input logic [VALUE_W-1:0] word);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= signed_mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] power_of_ten(input int n);
    logic [VALUE_W-1:0] p;
    p = 1;
    repeat (n) p = p * 10;
    return p;
  endfunction

  function automatic logic [VALUE_W-1:0] random_word();
    logic [VALUE_W-1:0] w;
    case ($urandom_range(0, 4))
      0: w = $urandom;
      1: w = $urandom >> $urandom_range(0, 31);
      // negated values of random size give signed texts of varying length
      2: w = -($urandom >> $urandom_range(1, 31));
      3: w = power_of_ten($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
      default: begin
        case ($urandom_range(0, 2))
          0: w = $urandom_range(0, 20);
          1: w = 32'h8000_0000 + $urandom_range(0, 3) - 2;
          default: w = 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
      end
    endcase
    return w;
  endfunction

  initial begin
    int i;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero, single digits, decade boundaries, full range and the sign edge
    send_word(1'b0, 32'd0);
    send_word(1'b1, 32'd0);
    send_word(1'b0, 32'd1);
    send_word(1'b1, 32'd9);
    send_word(1'b0, 32'd10);
    send_word(1'b1, 32'd99);
    send_word(1'b0, 32'd100);
    send_word(1'b0, 32'd999_999_999);
    send_word(1'b0, 32'd1_000_000_000);
    send_word(1'b0, 32'hFFFF_FFFF);
    send_word(1'b1, 32'hFFFF_FFFF);
    send_word(1'b1, 32'h8000_0000);
    send_word(1'b0, 32'h8000_0000);
    send_word(1'b1, 32'h7FFF_FFFF);
    send_word(1'b0, 32'h7FFF_FFFF);
    send_word(1'b1, 32'h8000_0001);
    send_word(1'b1, -32'd10);
    send_word(1'b1, -32'd1_000_000_000);
    send_word(1'b0, 32'hAAAA_AAAA);
    send_word(1'b1, 32'h5555_5555);
    send_word(1'b1, 32'hAAAA_AAAA);
    send_word(1'b0, 32'd4_294_967_290);

    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_word($urandom_range(0, 1), random_word());
    end
    in_tvalid <= 1'b0;

    while (chars_due != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/itda_pkg.sv
src/itda_dabble.sv
src/itda_emit.sv
src/integer_to_decimal_ascii_core.sv
sim/itda_text_checker.sv
sim/tb.sv
